// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/brbb_pkg.sv -----
package brbb_pkg;

    // design limits
    localparam int MAX_DIMENSION = 4096;
    localparam int MAX_FACTOR    = 16;

    localparam int POS_W = $clog2(MAX_DIMENSION);      // position / index bits
    localparam int DIM_W = POS_W + 1;                  // holds MAX_DIMENSION itself
    localparam int PH_W  = $clog2(MAX_FACTOR);         // phase bits
    localparam int N_W   = PH_W + 1;                   // holds MAX_FACTOR itself

    // fixed field widths
    localparam int PIX_W  = 8;
    localparam int FRAC_W = 9;
    localparam int ROI_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // intermediate widths of the roi arithmetic
    localparam int YA_W   = POS_W + 8 + 2;             // rs*256 + span*frac
    localparam int HB_W   = POS_W + FRAC_W;            // span*frac
    localparam int PROD_W = YA_W + N_W;                // scaled by factor

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START_FRC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_FRC    = 3'd5;

    // register reset values
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(480);
    localparam logic [PIX_W-1:0]  RST_THRESHOLD    = PIX_W'(128);
    localparam logic [N_W-1:0]    RST_FACTOR       = N_W'(4);
    localparam logic [FRAC_W-1:0] RST_ROW_START    = FRAC_W'(0);
    localparam logic [FRAC_W-1:0] RST_HEIGHT_FRC   = FRAC_W'(256);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_SCALE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // pixel word taken this cycle
        logic mul;      // first multiply stage of the roi
        logic scale;    // scale by factor and load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic frame_end;   // presented pixel closes the frame
        logic may_end;     // next pixel could close a frame whatever its payload
    } t_sts;

    // saturate an roi product to the output width
    function automatic logic [ROI_W-1:0] sat_roi(input logic [PROD_W-1:0] v);
        logic [ROI_W-1:0] res;
        if (v > PROD_W'((1 << ROI_W) - 1)) begin
            res = '1;
        end else begin
            res = v[ROI_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/brbb_pix_if.sv -----
interface brbb_pix_if;
    logic                         valid;
    logic                         ready;
    logic [brbb_pkg::PIX_W-1:0]   pixel;
    logic                         frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ----- sv/brbb_roi_if.sv -----
interface brbb_roi_if;
    logic                         valid;
    logic                         ready;
    logic [brbb_pkg::ROI_W-1:0]   roi_x;
    logic [brbb_pkg::ROI_W-1:0]   roi_y;
    logic [brbb_pkg::ROI_W-1:0]   roi_w;
    logic [brbb_pkg::ROI_W-1:0]   roi_h;

    modport source (output valid, output roi_x, output roi_y, output roi_w, output roi_h,
                    input ready);
    modport sink   (input valid, input roi_x, input roi_y, input roi_w, input roi_h,
                    output ready);
endinterface

// ----- sv/brbb_dp.sv -----
module brbb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brbb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [brbb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [brbb_pkg::PIX_W-1:0]        i_pixel,
    input  logic                              i_frame_start,
    input  brbb_pkg::t_cmd                    i_cmd,
    output brbb_pkg::t_sts                    o_sts,
    output logic [brbb_pkg::ROI_W-1:0]        o_roi_x,
    output logic [brbb_pkg::ROI_W-1:0]        o_roi_y,
    output logic [brbb_pkg::ROI_W-1:0]        o_roi_w,
    output logic [brbb_pkg::ROI_W-1:0]        o_roi_h
);

    localparam int POS_W  = brbb_pkg::POS_W;
    localparam int DIM_W  = brbb_pkg::DIM_W;
    localparam int PH_W   = brbb_pkg::PH_W;
    localparam int N_W    = brbb_pkg::N_W;
    localparam int FRAC_W = brbb_pkg::FRAC_W;
    localparam int YA_W   = brbb_pkg::YA_W;
    localparam int HB_W   = brbb_pkg::HB_W;
    localparam int PROD_W = brbb_pkg::PROD_W;
    localparam int ROI_W  = brbb_pkg::ROI_W;

    // configuration registers
    logic [DIM_W-1:0]            r_width, r_height;
    logic [brbb_pkg::PIX_W-1:0]  r_thresh;
    logic [N_W-1:0]              r_factor;
    logic [FRAC_W-1:0]           r_rsf, r_hf;

    // scan state
    logic [POS_W-1:0] r_col_pos, r_row_pos, r_samp_col, r_samp_row;
    logic [PH_W-1:0]  r_col_ph, r_row_ph;
    logic [POS_W-1:0] r_first_col, r_last_col, r_first_row, r_last_row;
    logic [POS_W-1:0] n_col_pos, n_row_pos, n_samp_col, n_samp_row;
    logic [PH_W-1:0]  n_col_ph, n_row_ph;
    logic [POS_W-1:0] n_first_col, n_last_col, n_first_row, n_last_row;

    // frame snapshot and roi pipeline
    logic [POS_W-1:0] r_cs, r_cspan, r_rs, r_rspan;
    logic [YA_W-1:0]  r_ya;
    logic [HB_W-1:0]  r_hb;
    logic [ROI_W-1:0] r_roi_x, r_roi_y, r_roi_w, r_roi_h;

    logic [DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
    logic [N_W-1:0]   n_eff;
    logic [POS_W-1:0] c_col_pos, c_row_pos, c_samp_col, c_samp_row;
    logic [PH_W-1:0]  c_col_ph, c_row_ph;
    logic [POS_W-1:0] c_first_col, c_last_col, c_first_row, c_last_row;
    logic             col_s, row_s, hit, end_row, frame_end;
    logic [POS_W-1:0] h_first_col, h_last_col, h_first_row, h_last_row;
    logic [PROD_W-1:0] p_x, p_y, p_w, p_h;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= brbb_pkg::RST_IMAGE_WIDTH;
            r_height <= brbb_pkg::RST_IMAGE_HEIGHT;
            r_thresh <= brbb_pkg::RST_THRESHOLD;
            r_factor <= brbb_pkg::RST_FACTOR;
            r_rsf    <= brbb_pkg::RST_ROW_START;
            r_hf     <= brbb_pkg::RST_HEIGHT_FRC;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brbb_pkg::CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[DIM_W-1:0];
                brbb_pkg::CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[DIM_W-1:0];
                brbb_pkg::CFG_THRESHOLD:     r_thresh <= i_cfg_data[brbb_pkg::PIX_W-1:0];
                brbb_pkg::CFG_FACTOR:        r_factor <= i_cfg_data[N_W-1:0];
                brbb_pkg::CFG_ROW_START_FRC: r_rsf    <= i_cfg_data[FRAC_W-1:0];
                brbb_pkg::CFG_HEIGHT_FRC:    r_hf     <= i_cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp dimensions and factor to their legal ranges
    always_comb begin
        w_eff = (r_width == '0) ? DIM_W'(1)
              : (r_width > DIM_W'(brbb_pkg::MAX_DIMENSION)) ? DIM_W'(brbb_pkg::MAX_DIMENSION)
              : r_width;
        h_eff = (r_height == '0) ? DIM_W'(1)
              : (r_height > DIM_W'(brbb_pkg::MAX_DIMENSION)) ? DIM_W'(brbb_pkg::MAX_DIMENSION)
              : r_height;
        n_eff = (r_factor == '0) ? N_W'(1)
              : (r_factor > N_W'(brbb_pkg::MAX_FACTOR)) ? N_W'(brbb_pkg::MAX_FACTOR)
              : r_factor;
        w_m1 = w_eff - DIM_W'(1);
        h_m1 = h_eff - DIM_W'(1);
    end

    // a frame start mark restarts the scan at this pixel
    always_comb begin
        c_col_pos   = i_frame_start ? '0 : r_col_pos;
        c_row_pos   = i_frame_start ? '0 : r_row_pos;
        c_samp_col  = i_frame_start ? '0 : r_samp_col;
        c_samp_row  = i_frame_start ? '0 : r_samp_row;
        c_col_ph    = i_frame_start ? '0 : r_col_ph;
        c_row_ph    = i_frame_start ? '0 : r_row_ph;
        c_first_col = i_frame_start ? '0 : r_first_col;
        c_last_col  = i_frame_start ? '0 : r_last_col;
        c_first_row = i_frame_start ? '0 : r_first_row;
        c_last_row  = i_frame_start ? '0 : r_last_row;
    end

    // sampling, hit test and first/last tracking
    always_comb begin
        col_s = (c_col_ph == '0) && (({1'b0, c_col_pos} + DIM_W'(n_eff)) <= w_eff);
        row_s = (c_row_ph == '0) && (({1'b0, c_row_pos} + DIM_W'(n_eff)) <= h_eff);
        hit   = col_s && row_s && (i_pixel > r_thresh);

        h_first_col = c_first_col;
        h_last_col  = c_last_col;
        h_first_row = c_first_row;
        h_last_row  = c_last_row;
        if (hit) begin
            if ((c_samp_col != '0) && ((c_first_col == '0) || (c_samp_col < c_first_col))) begin
                h_first_col = c_samp_col;
            end
            if (c_samp_col > c_last_col) begin
                h_last_col = c_samp_col;
            end
            if ((c_samp_row != '0) && ((c_first_row == '0) || (c_samp_row < c_first_row))) begin
                h_first_row = c_samp_row;
            end
            if (c_samp_row > c_last_row) begin
                h_last_row = c_samp_row;
            end
        end

        end_row   = {1'b0, c_col_pos} >= w_m1;
        frame_end = end_row && ({1'b0, c_row_pos} >= h_m1);
    end

    // status for the controller
    always_comb begin
        o_sts.frame_end = frame_end;
        o_sts.may_end   = (({1'b0, r_col_pos} >= w_m1) && ({1'b0, r_row_pos} >= h_m1))
                       || ((w_m1 == '0) && (h_m1 == '0));
    end

    // next scan state
    always_comb begin
        n_col_pos   = c_col_pos;
        n_row_pos   = c_row_pos;
        n_samp_col  = c_samp_col;
        n_samp_row  = c_samp_row;
        n_col_ph    = c_col_ph;
        n_row_ph    = c_row_ph;
        n_first_col = h_first_col;
        n_last_col  = h_last_col;
        n_first_row = h_first_row;
        n_last_row  = h_last_row;
        if (frame_end) begin
            n_col_pos   = '0;
            n_row_pos   = '0;
            n_samp_col  = '0;
            n_samp_row  = '0;
            n_col_ph    = '0;
            n_row_ph    = '0;
            n_first_col = '0;
            n_last_col  = '0;
            n_first_row = '0;
            n_last_row  = '0;
        end else if (end_row) begin
            n_col_pos  = '0;
            n_col_ph   = '0;
            n_samp_col = '0;
            if (({1'b0, c_row_ph} + N_W'(1)) >= n_eff) begin
                n_row_ph   = '0;
                n_samp_row = c_samp_row + POS_W'(1);
            end else begin
                n_row_ph = c_row_ph + PH_W'(1);
            end
            n_row_pos = c_row_pos + POS_W'(1);
        end else begin
            if (({1'b0, c_col_ph} + N_W'(1)) >= n_eff) begin
                n_col_ph   = '0;
                n_samp_col = c_samp_col + POS_W'(1);
            end else begin
                n_col_ph = c_col_ph + PH_W'(1);
            end
            n_col_pos = c_col_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_samp_col  <= '0;
            r_samp_row  <= '0;
            r_col_ph    <= '0;
            r_row_ph    <= '0;
            r_first_col <= '0;
            r_last_col  <= '0;
            r_first_row <= '0;
            r_last_row  <= '0;
        end else if (i_cmd.accept) begin
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_samp_col  <= n_samp_col;
            r_samp_row  <= n_samp_row;
            r_col_ph    <= n_col_ph;
            r_row_ph    <= n_row_ph;
            r_first_col <= n_first_col;
            r_last_col  <= n_last_col;
            r_first_row <= n_first_row;
            r_last_row  <= n_last_row;
        end
    end

    // snapshot of the hit box on the closing pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && frame_end) begin
            r_cs    <= h_first_col;
            r_cspan <= (h_last_col >= h_first_col) ? (h_last_col - h_first_col) : '0;
            r_rs    <= h_first_row;
            r_rspan <= (h_last_row >= h_first_row) ? (h_last_row - h_first_row) : '0;
        end
    end

    // first stage: row start plus span times start fraction, span times height fraction
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_ya <= YA_W'({r_rs, 8'h00}) + YA_W'(r_rspan) * YA_W'(r_rsf);
            r_hb <= HB_W'(r_rspan) * HB_W'(r_hf);
        end
    end

    // second stage: scale by factor, drop the fraction, saturate
    always_comb begin
        p_x = PROD_W'(r_cs) * PROD_W'(n_eff);
        p_w = PROD_W'(r_cspan) * PROD_W'(n_eff);
        p_y = (PROD_W'(r_ya) * PROD_W'(n_eff)) >> 8;
        p_h = (PROD_W'(r_hb) * PROD_W'(n_eff)) >> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_roi_x <= brbb_pkg::sat_roi(p_x);
            r_roi_y <= brbb_pkg::sat_roi(p_y);
            r_roi_w <= brbb_pkg::sat_roi(p_w);
            r_roi_h <= brbb_pkg::sat_roi(p_h);
        end
    end

    assign o_roi_x = r_roi_x;
    assign o_roi_y = r_roi_y;
    assign o_roi_w = r_roi_w;
    assign o_roi_h = r_roi_h;

endmodule

// ----- sv/brbb_ctrl.sv -----
`include "assert_macros.svh"

module brbb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  brbb_pkg::t_sts  i_sts,
    output brbb_pkg::t_cmd  o_cmd
);

    brbb_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             in_ready, in_accept;

    // pixel intake: only in the run state, and a closing pixel waits while the output word is still held
    always_comb begin
        in_ready  = (r_state == brbb_pkg::ST_RUN) && !(r_out_valid && i_sts.may_end);
        in_accept = i_in_valid && in_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brbb_pkg::ST_RUN: begin
                if (in_accept && i_sts.frame_end) begin
                    n_state = brbb_pkg::ST_MUL;
                end
            end
            brbb_pkg::ST_MUL:   n_state = brbb_pkg::ST_SCALE;
            brbb_pkg::ST_SCALE: n_state = brbb_pkg::ST_RUN;
            default:            n_state = brbb_pkg::ST_RUN;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.accept = in_accept;
        o_cmd.mul    = 1'b0;
        o_cmd.scale  = 1'b0;
        case (r_state)
            brbb_pkg::ST_MUL:   o_cmd.mul   = 1'b1;
            brbb_pkg::ST_SCALE: o_cmd.scale = 1'b1;
            default: ;
        endcase
    end

    // output word flag
    always_comb begin
        if (r_state == brbb_pkg::ST_SCALE) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brbb_pkg::ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    // checks
    `ASSERT_NEXT(a_end_starts_calc, i_clk, i_rst_n, in_accept && i_sts.frame_end, r_state == brbb_pkg::ST_MUL, "closing pixel did not start the roi calculation")
    `ASSERT_NEXT(a_scale_loads_out, i_clk, i_rst_n, r_state == brbb_pkg::ST_SCALE, r_out_valid, "roi not presented after scaling")
    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n, !(r_out_valid && in_accept && i_sts.frame_end), "closing pixel taken while the output word is still held")
    `ASSERT_ALWAYS(a_busy_blocks_in, i_clk, i_rst_n, (r_state == brbb_pkg::ST_RUN) || !in_accept, "pixel taken during the roi calculation")

endmodule

// ----- sv/bright_region_bounding_box_core.sv -----
// Bright-region bounding box over a streamed grey frame.
// i_pix carries one 8-bit pixel per word in raster order; frame_start marks row 0
// column 0 and drops any partial frame. Every Nth column and row is sampled and
// compared against the threshold; at the last pixel of a frame one roi word
// (x, y, w, h, each saturated at 4095) goes out on o_roi.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (width,
// height, threshold, factor, row start fraction, height fraction); write only
// while no frame is in flight and no roi is pending.
// Throughput: one pixel per cycle while a frame streams in, save for the pauses
// below. The closing pixel starts a two-step roi calculation (fraction multiply,
// then factor scaling); the roi word becomes valid after the scaling step, and
// pixel intake pauses while the calculation runs.
// The roi sits in an output register; pixels keep flowing while it waits, and
// only a pixel at the closing position of the next frame is held back until
// the roi is taken.
// Reset (synchronous, active low) restores register defaults, clears the scan
// position and hit box, and drops any pending roi. No memory needs clearing.
module bright_region_bounding_box_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [brbb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [brbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    brbb_pix_if.sink                         i_pix,
    brbb_roi_if.source                       o_roi
);

    brbb_pkg::t_cmd cmd;
    brbb_pkg::t_sts sts;

    // sequencing and handshakes
    brbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_roi.valid),
        .i_out_ready (o_roi.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // scan, hit tracking and roi arithmetic
    brbb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_roi_x       (o_roi.roi_x),
        .o_roi_y       (o_roi.roi_y),
        .o_roi_w       (o_roi.roi_w),
        .o_roi_h       (o_roi.roi_h)
    );

endmodule

// ----- tb/roi_checker.sv -----
`timescale 1ns / 1ps

module roi_checker
    import brbb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    brbb_pix_if                   i_pix,
    brbb_roi_if                   i_roi,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [ROI_W-1:0] x;
        logic [ROI_W-1:0] y;
        logic [ROI_W-1:0] w;
        logic [ROI_W-1:0] h;
    } roi_t;

    // rois predicted from accepted pixel words, oldest first
    roi_t roi_expected_q[$];
    int   fail_total = 0;

    // shadow copy of the register file
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [PIX_W-1:0]  thresh_reg;
    logic [N_W-1:0]    factor_reg;
    logic [FRAC_W-1:0] row_start_reg;
    logic [FRAC_W-1:0] height_frc_reg;

    // scan position and hit box
    logic [POS_W-1:0] col_pos, row_pos;
    logic [PH_W-1:0]  col_ph, row_ph;
    logic [POS_W-1:0] samp_col, samp_row;
    logic [POS_W-1:0] first_col, last_col, first_row, last_row;

    function automatic logic [31:0] clamp_u(input logic [31:0] v, input logic [31:0] lo,
                                            input logic [31:0] hi);
        logic [31:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    function automatic logic [ROI_W-1:0] clip_roi(input logic [31:0] v);
        logic [ROI_W-1:0] res;
        res = (v > 32'd4095) ? '1 : v[ROI_W-1:0];
        return res;
    endfunction

    task automatic clear_scan();
        col_pos   = '0;
        row_pos   = '0;
        col_ph    = '0;
        row_ph    = '0;
        samp_col  = '0;
        samp_row  = '0;
        first_col = '0;
        last_col  = '0;
        first_row = '0;
        last_row  = '0;
    endtask

    // index 0 never opens a box and never extends its end
    task automatic mark_hit(input logic [POS_W-1:0] idx, inout logic [POS_W-1:0] first,
                            inout logic [POS_W-1:0] last);
        if (idx != '0 && (first == '0 || idx < first)) begin
            first = idx;
        end
        if (idx > last) begin
            last = idx;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:   width_reg      = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:  height_reg     = data[DIM_W-1:0];
            CFG_THRESHOLD:     thresh_reg     = data[PIX_W-1:0];
            CFG_FACTOR:        factor_reg     = data[N_W-1:0];
            CFG_ROW_START_FRC: row_start_reg  = data[FRAC_W-1:0];
            CFG_HEIGHT_FRC:    height_frc_reg = data[FRAC_W-1:0];
            default: ;
        endcase
    endtask

    // advance the scan by one pixel word and queue the roi if it closes the frame
    task automatic scan_pixel(input logic [PIX_W-1:0] px, input logic fs);
        logic [31:0] w, h, n, cspan, rspan;
        logic        col_s, row_s, end_row;
        roi_t        box;
        w = clamp_u(32'(width_reg), 1, MAX_DIMENSION);
        h = clamp_u(32'(height_reg), 1, MAX_DIMENSION);
        n = clamp_u(32'(factor_reg), 1, MAX_FACTOR);

        if (fs) begin
            clear_scan();
        end

        col_s = (col_ph == '0) && (32'(col_pos) + n <= w);
        row_s = (row_ph == '0) && (32'(row_pos) + n <= h);
        if (col_s && row_s && px > thresh_reg) begin
            mark_hit(samp_col, first_col, last_col);
            mark_hit(samp_row, first_row, last_row);
        end

        end_row = 32'(col_pos) >= w - 1;
        if (end_row && 32'(row_pos) >= h - 1) begin
            cspan = (last_col >= first_col) ? 32'(last_col - first_col) : 32'd0;
            rspan = (last_row >= first_row) ? 32'(last_row - first_row) : 32'd0;
            box.x = clip_roi(32'(first_col) * n);
            box.y = clip_roi((((32'(first_row) << 8) + rspan * 32'(row_start_reg)) * n) >> 8);
            box.w = clip_roi(cspan * n);
            box.h = clip_roi((rspan * 32'(height_frc_reg) * n) >> 8);
            roi_expected_q = {roi_expected_q, box};
            clear_scan();
        end else if (end_row) begin
            col_pos  = '0;
            col_ph   = '0;
            samp_col = '0;
            if (32'(row_ph) + 1 >= n) begin
                row_ph   = '0;
                samp_row = samp_row + 1'b1;
            end else begin
                row_ph = row_ph + 1'b1;
            end
            row_pos = row_pos + 1'b1;
        end else begin
            if (32'(col_ph) + 1 >= n) begin
                col_ph   = '0;
                samp_col = samp_col + 1'b1;
            end else begin
                col_ph = col_ph + 1'b1;
            end
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic compare_field(input string field, input logic [ROI_W-1:0] exp_v,
                                 input logic [ROI_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
            fail_total++;
        end
    endtask

    // compare an accepted roi word with the oldest prediction
    task automatic check_roi();
        roi_t box;
        if (roi_expected_q.size() == 0) begin
            $error("roi word with nothing expected: x=%0d y=%0d w=%0d h=%0d",
                   i_roi.roi_x, i_roi.roi_y, i_roi.roi_w, i_roi.roi_h);
            fail_total++;
        end else begin
            box = roi_expected_q.pop_front();
            compare_field("roi_x", box.x, i_roi.roi_x);
            compare_field("roi_y", box.y, i_roi.roi_y);
            compare_field("roi_w", box.w, i_roi.roi_w);
            compare_field("roi_h", box.h, i_roi.roi_h);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg      = RST_IMAGE_WIDTH;
            height_reg     = RST_IMAGE_HEIGHT;
            thresh_reg     = RST_THRESHOLD;
            factor_reg     = RST_FACTOR;
            row_start_reg  = RST_ROW_START;
            height_frc_reg = RST_HEIGHT_FRC;
            clear_scan();
            roi_expected_q.delete();
        end else begin
            if (i_roi.valid && i_roi.ready) begin
                check_roi();
            end
            if (i_cfg_we) begin
                write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_pix.valid && i_pix.ready) begin
                scan_pixel(i_pix.pixel, i_pix.frame_start);
            end
        end
        o_pending    <= roi_expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import brbb_pkg::*;

    localparam int LIMIT_CYCLES   = 2_000_000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int LONG_HOLD      = 300;
    localparam int ITEMS_TARGET   = 450;
    localparam int RESULTS_WANTED = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    brbb_pix_if pix_if ();
    brbb_roi_if roi_if ();

    int fail_count;
    int pending;
    int cycle_count;
    int frames_done;
    int mixed_items;
    int eff_w;
    int eff_h;
    int cur_thr;
    bit quiet;
    bit hold_req;

    bright_region_bounding_box_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_if),
        .o_roi       (roi_if)
    );

    roi_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_if),
        .i_roi        (roi_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // roi receiver: random stall bursts, one long hold on request
    initial begin
        int  burst;
        bit  hold_served;
        burst       = 0;
        hold_served = 1'b0;
        roi_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                roi_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (burst > 0) begin
                roi_if.ready <= 1'b0;
                burst--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 10);
                roi_if.ready <= 1'b0;
            end else begin
                roi_if.ready <= 1'b1;
            end
        end
    end

    // offer one pixel word, optionally after a gap, and wait for its handshake
    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= px;
        pix_if.frame_start <= fs;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        mixed_items++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(negedge i_clk);
    endtask

    task automatic set_regs(input int w, input int h, input int thr, input int fac,
                            input int rsf, input int hf);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FACTOR, fac);
        write_reg(CFG_ROW_START_FRC, rsf);
        write_reg(CFG_HEIGHT_FRC, hf);
        cfg_we  <= 1'b0;
        eff_w   = (w < 1) ? 1 : (w > MAX_DIMENSION) ? MAX_DIMENSION : w;
        eff_h   = (h < 1) ? 1 : (h > MAX_DIMENSION) ? MAX_DIMENSION : h;
        cur_thr = thr;
    endtask

    // stop offering and wait until every predicted roi has come out
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int pick_fraction();
        int res;
        case ($urandom_range(0, 3))
            0: res = 0;
            1: res = 256;
            2: res = 511;
            default: res = $urandom_range(0, 511);
        endcase
        return res;
    endfunction

    function automatic int pick_threshold();
        int res;
        case ($urandom_range(0, 3))
            0: res = 0;
            1: res = 255;
            default: res = $urandom_range(0, 255);
        endcase
        return res;
    endfunction

    // grey levels clustered around the threshold plus the extremes
    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] res;
        case ($urandom_range(0, 5))
            0, 1: res = PIX_W'($urandom_range(0, 255));
            2: res = PIX_W'(cur_thr);
            3: res = PIX_W'(cur_thr + 1);
            4: res = '0;
            default: res = '1;
        endcase
        return res;
    endfunction

    // mostly dark, with rare bright spots above a threshold of 100
    function automatic logic [PIX_W-1:0] sparse_pixel(input bit dense);
        logic [PIX_W-1:0] res;
        if ($urandom_range(0, dense ? 15 : 511) == 0) begin
            res = PIX_W'($urandom_range(101, 255));
        end else begin
            res = PIX_W'($urandom_range(0, 100));
        end
        return res;
    endfunction

    // whole frame, or only its first cut words when cut is nonzero
    task automatic send_frame(input int cut, input bit fs_first);
        int total;
        total = (cut > 0) ? cut : eff_w * eff_h;
        for (int i = 0; i < total; i++) begin
            push_pixel(pick_pixel(), (i == 0) && fs_first);
        end
        if (cut == 0) begin
            frames_done++;
        end
    endtask

    // edge values, partial frames and register extremes on tiny frames
    task automatic directed_part();
        set_regs(3, 2, 0, 1, 0, 256);
        push_pixel(8'd0, 1'b1);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd1, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd128, 1'b0);
        // frame restarted by a second start mark before it completes
        push_pixel(8'd200, 1'b1);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd7, 1'b1);
        push_pixel(8'd9, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b0);
        drain();
        // zero factor acts as one, one-pixel frames, hit only at index 0
        set_regs(1, 1, 254, 0, 256, 0);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd254, 1'b0);
        push_pixel(8'd0, 1'b1);
        drain();
        // zero dimensions, oversized factor, top threshold, fractions past one
        set_regs(0, 0, 255, 31, 511, 511);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd255, 1'b0);
        drain();
    endtask

    // random registers, a few small frames, some cut short
    task automatic random_phase();
        int w, h, fac, frames, total, cut;
        bit big, need_fs;
        big = ($urandom_range(0, 11) == 0);
        if (big) begin
            w      = $urandom_range(16, 20);
            h      = $urandom_range(1, 3);
            fac    = $urandom_range(16, 31);
            frames = 1;
        end else begin
            w      = $urandom_range(0, 12);
            h      = $urandom_range(0, 8);
            fac    = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 5);
            frames = $urandom_range(1, 4);
        end
        set_regs(w, h, pick_threshold(), fac, pick_fraction(), pick_fraction());
        need_fs = 1'b0;
        for (int f = 0; f < frames; f++) begin
            total = eff_w * eff_h;
            cut   = 0;
            if (f < frames - 1 && total > 1 && $urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, total - 1);
            end
            send_frame(cut, need_fs || ($urandom_range(0, 3) != 0));
            need_fs = (cut != 0);
        end
        drain();
    endtask

    // two-word frames against a long receiver hold so the block backs up
    task automatic pressure_phase();
        set_regs(2, 1, pick_threshold(), 1, pick_fraction(), pick_fraction());
        hold_req <= 1'b1;
        for (int f = 0; f < 30; f++) begin
            send_frame(0, 1'b1);
        end
        drain();
        hold_req <= 1'b0;
    endtask

    // tall single-column frame with fractions past one
    task automatic large_frames();
        set_regs(1, 64, 100, 1, 511, 511);
        for (int i = 0; i < eff_h; i++) begin
            push_pixel(sparse_pixel(1'b1), i == 0);
        end
        frames_done++;
        drain();
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel       = '0;
        pix_if.frame_start = 1'b0;
        quiet              = 1'b0;
        hold_req           = 1'b0;
        frames_done        = 0;
        mixed_items        = 0;
        eff_w              = 1;
        eff_h              = 1;
        cur_thr            = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_part();
        while (mixed_items < ITEMS_TARGET / 3) begin
            random_phase();
        end
        pressure_phase();
        large_frames();
        while (mixed_items < ITEMS_TARGET - 60 || frames_done < RESULTS_WANTED) begin
            random_phase();
        end
        // closing stretch with no idling on either side
        quiet = 1'b1;
        do begin
            random_phase();
        end while (mixed_items < ITEMS_TARGET);

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
